// ===== hdl/udp_port_demux_receive_queues_top_assert.svh =====
// Assertion macros for the receive queue block.
`ifndef UDP_PORT_DEMUX_RECEIVE_QUEUES_TOP_ASSERT_SVH
`define UDP_PORT_DEMUX_RECEIVE_QUEUES_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define UPD_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define UPD_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`else
`define UPD_ASSERT_IMPL(label, clk, rst, prop, msg)
`define UPD_ASSERT_NEXT(label, clk, rst, cond, prop, msg)
`endif
`endif

// ===== hdl/updrq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package updrq_pkg;
   localparam int PORT_SLOTS_DEF  = 16;
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int HANDLE_BITS_DEF = 10;
   localparam logic [31:0] LOCAL_IP_RESET  = 32'h0A00020F;
   localparam logic [47:0] LOCAL_MAC_RESET = 48'h525400123456;
   localparam logic [7:0]  UDP_PROTO = 8'd17;
   localparam logic [15:0] UDP_HDR   = 16'd8;

   localparam logic [1:0] OP_BIND    = 2'd0;
   localparam logic [1:0] OP_DELIVER = 2'd1;
   localparam logic [1:0] OP_RECEIVE = 2'd2;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_BOUND      = 3'd1;
   localparam logic [2:0] ST_TABLE_FULL = 3'd2;
   localparam logic [2:0] ST_NOT_BOUND  = 3'd3;
   localparam logic [2:0] ST_EMPTY      = 3'd4;
   localparam logic [2:0] ST_MISMATCH   = 3'd5;
   localparam logic [2:0] ST_QUEUE_FULL = 3'd6;
   localparam logic [2:0] ST_BAD_LENGTH = 3'd7;

   localparam logic [0:0] REG_LOCAL_IP  = 1'd0;
   localparam logic [0:0] REG_LOCAL_MAC = 1'd1;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] port;
      logic [31:0] source_ip;
      logic [15:0] source_port;
      logic [31:0] dest_ip;
      logic [47:0] dest_mac;
      logic [7:0]  protocol;
      logic [15:0] udp_length;
      logic [9:0]  payload_handle;
      logic [15:0] max_len;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] out_source_ip;
      logic [15:0] out_source_port;
      logic [9:0]  out_handle;
      logic [15:0] out_length;
   } rsp_type;

   // Classified command handed from the front to the back.
   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] port;
      logic        addr_ok;
      logic        len_ok;
      logic [31:0] source_ip;
      logic [15:0] source_port;
      logic [9:0]  handle;
      logic [15:0] length;
      logic [15:0] max_len;
   } cmd_type;
endpackage
`default_nettype wire

// ===== hdl/updrq_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module updrq_front
   import updrq_pkg::*;
   (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    csr_psel,
   input  wire logic    csr_penable,
   input  wire logic    csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [63:0] csr_pwdata,
   output logic [63:0]  csr_prdata,
   input  wire logic    req_push,
   input  wire req_type req_data,
   output logic         req_full,
   output logic         cmd_valid,
   output cmd_type      cmd_data,
   input  wire logic    cmd_pop
   );
   logic [31:0] ip_ff;
   logic [47:0] mac_ff;
   cmd_type q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic rd_ff, wr_ff;
   logic push_ok, pop_ok;
   cmd_type c;

   assign req_full = cnt_ff == 2'd2;
   assign push_ok = req_push && !req_full && req_data.opcode != 2'd3;
   assign cmd_valid = cnt_ff != 2'd0;
   assign pop_ok = cmd_pop && cmd_valid;
   assign cmd_data = q_ff[rd_ff];

   always_comb begin
      c.opcode = req_data.opcode;
      c.port = req_data.port;
      c.addr_ok = req_data.dest_ip == ip_ff && req_data.dest_mac == mac_ff &&
                  req_data.protocol == UDP_PROTO;
      c.len_ok = req_data.udp_length >= UDP_HDR;
      c.source_ip = req_data.source_ip;
      c.source_port = req_data.source_port;
      c.handle = req_data.payload_handle;
      c.length = req_data.udp_length - UDP_HDR;
      c.max_len = req_data.max_len;
      cnt_in = cnt_ff + {1'b0, push_ok} - {1'b0, pop_ok};
   end

   always_comb begin
      case (csr_paddr[3])
         REG_LOCAL_IP: csr_prdata = {32'd0, ip_ff};
         default: csr_prdata = {16'd0, mac_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ip_ff <= LOCAL_IP_RESET;
         mac_ff <= LOCAL_MAC_RESET;
         cnt_ff <= 2'd0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2:0] == 3'd0) begin
            case (csr_paddr[3])
               REG_LOCAL_IP: ip_ff <= csr_pwdata[31:0];
               default: mac_ff <= csr_pwdata[47:0];
            endcase
         end
         cnt_ff <= cnt_in;
         if (push_ok) wr_ff <= !wr_ff;
         if (pop_ok) rd_ff <= !rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) q_ff[wr_ff] <= c;
   end
endmodule
`default_nettype wire

// ===== hdl/updrq_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module updrq_back
   import updrq_pkg::*;
   #(
   parameter int PORT_SLOTS  = PORT_SLOTS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
   ) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_valid,
   input  wire cmd_type cmd_data,
   output logic         cmd_pop,
   output logic         rsp_empty,
   output rsp_type      rsp_data,
   input  wire logic    rsp_pop
   );
   `include "udp_port_demux_receive_queues_top_assert.svh"
   localparam int HANDLE_BITS = HANDLE_BITS_DEF;
   localparam int SW = (PORT_SLOTS > 1) ? $clog2(PORT_SLOTS) : 1;
   localparam int QW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int EW = 32 + 16 + HANDLE_BITS + 16;

   logic [PORT_SLOTS-1:0] used_ff;
   logic [15:0] sport_ff [PORT_SLOTS];
   logic [QW-1:0] head_ff [PORT_SLOTS];
   logic [QW-1:0] tail_ff [PORT_SLOTS];
   logic [CW-1:0] count_ff [PORT_SLOTS];
   logic [EW-1:0] mem [2**(SW+QW)];
   logic [EW-1:0] rd_ff;

   logic rd_wait_ff;
   logic [15:0] max_ff;
   logic out_v_ff;
   rsp_type out_ff;

   logic hit, has_free;
   logic [SW-1:0] hit_idx, free_idx;
   logic [SW+QW-1:0] addr;
   logic busy;

   always_comb begin
      hit = 1'b0; hit_idx = '0; has_free = 1'b0; free_idx = '0;
      for (int i = PORT_SLOTS - 1; i >= 0; i--) begin
         if (used_ff[i] && sport_ff[i] == cmd_data.port) begin
            hit = 1'b1; hit_idx = SW'(i);
         end
         if (!used_ff[i]) begin
            has_free = 1'b1; free_idx = SW'(i);
         end
      end
   end

   assign busy = rd_wait_ff || out_v_ff;
   assign cmd_pop = cmd_valid && !busy;
   assign rsp_empty = !out_v_ff;
   assign rsp_data = out_ff;

   always_comb begin
      case (cmd_data.opcode)
         OP_RECEIVE: addr = {hit_idx, head_ff[hit_idx]};
         default: addr = {hit_idx, tail_ff[hit_idx]};
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd_pop && cmd_data.opcode == OP_DELIVER && cmd_data.addr_ok &&
          cmd_data.len_ok && hit && count_ff[hit_idx] != CW'(QUEUE_DEPTH))
         mem[addr] <= {cmd_data.source_ip, cmd_data.source_port,
                       cmd_data.handle[HANDLE_BITS-1:0], cmd_data.length};
      rd_ff <= mem[addr];
      if (cmd_pop) max_ff <= cmd_data.max_len;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         rd_wait_ff <= 1'b0;
         out_v_ff <= 1'b0;
         for (int i = 0; i < PORT_SLOTS; i++) begin
            sport_ff[i] <= '0; head_ff[i] <= '0; tail_ff[i] <= '0; count_ff[i] <= '0;
         end
      end else begin
         if (out_v_ff && rsp_pop) out_v_ff <= 1'b0;
         rd_wait_ff <= 1'b0;
         if (rd_wait_ff) begin
            out_v_ff <= 1'b1;
            out_ff.out_source_ip <= rd_ff[EW-1 -: 32];
            out_ff.out_source_port <= rd_ff[EW-33 -: 16];
            out_ff.out_handle <= 10'(rd_ff[HANDLE_BITS+15:16]);
            out_ff.out_length <= (rd_ff[15:0] > max_ff) ? max_ff : rd_ff[15:0];
         end
         if (cmd_pop) begin
            out_ff <= '0;
            out_v_ff <= 1'b1;
            case (cmd_data.opcode)
               OP_BIND: begin
                  if (hit) out_ff.status <= ST_BOUND;
                  else if (!has_free) out_ff.status <= ST_TABLE_FULL;
                  else begin
                     out_ff.status <= ST_OK;
                     used_ff[free_idx] <= 1'b1;
                     sport_ff[free_idx] <= cmd_data.port;
                     head_ff[free_idx] <= '0;
                     tail_ff[free_idx] <= '0;
                     count_ff[free_idx] <= '0;
                  end
               end
               OP_DELIVER: begin
                  out_ff.out_handle <= 10'(cmd_data.handle[HANDLE_BITS-1:0]);
                  if (!cmd_data.addr_ok) out_ff.status <= ST_MISMATCH;
                  else if (!cmd_data.len_ok) out_ff.status <= ST_BAD_LENGTH;
                  else if (!hit) out_ff.status <= ST_NOT_BOUND;
                  else if (count_ff[hit_idx] == CW'(QUEUE_DEPTH))
                     out_ff.status <= ST_QUEUE_FULL;
                  else begin
                     out_ff.status <= ST_OK;
                     tail_ff[hit_idx] <= (tail_ff[hit_idx] == QW'(QUEUE_DEPTH - 1)) ?
                                         '0 : tail_ff[hit_idx] + 1'b1;
                     count_ff[hit_idx] <= count_ff[hit_idx] + 1'b1;
                  end
               end
               default: begin
                  if (!hit) out_ff.status <= ST_NOT_BOUND;
                  else if (count_ff[hit_idx] == '0) out_ff.status <= ST_EMPTY;
                  else begin
                     out_ff.status <= ST_OK;
                     out_v_ff <= 1'b0;
                     rd_wait_ff <= 1'b1;
                     head_ff[hit_idx] <= (head_ff[hit_idx] == QW'(QUEUE_DEPTH - 1)) ?
                                         '0 : head_ff[hit_idx] + 1'b1;
                     count_ff[hit_idx] <= count_ff[hit_idx] - 1'b1;
                  end
               end
            endcase
         end
      end
   end

   `UPD_ASSERT_NEXT(a_read_shows, clock, reset, rd_wait_ff, out_v_ff, "read result lost")
   `UPD_ASSERT_IMPL(a_no_pop_busy, clock, reset, !(cmd_pop && busy), "pop while busy")
   `UPD_ASSERT_NEXT(a_hold, clock, reset, out_v_ff && !rsp_pop, out_v_ff && $stable(out_ff),
                    "result changed while waiting")
endmodule
`default_nettype wire

// ===== hdl/udp_port_demux_receive_queues_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A request passes the two-entry request queue and then the single result register;
// a successful receive also passes the registered read port of the descriptor memory.
// The back end takes no new request until the result of the last one has been popped.
// Reset clears the port table, queue pointers and counts at once and loads the
// local address registers; descriptor storage is not cleared.
module udp_port_demux_receive_queues_top
   import updrq_pkg::*;
   #(
   parameter int PORT_SLOTS  = PORT_SLOTS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
   ) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    csr_psel,
   input  wire logic    csr_penable,
   input  wire logic    csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [63:0] csr_pwdata,
   output logic [63:0]  csr_prdata,
   output logic         csr_pready,
   input  wire logic    req_push,
   input  wire req_type req_data,
   output logic         req_full,
   output logic         rsp_empty,
   output rsp_type      rsp_data,
   input  wire logic    rsp_pop
   );
   logic cmd_valid, cmd_pop;
   cmd_type cmd_data;

   assign csr_pready = 1'b1;

   updrq_front u_front (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .req_push, .req_data, .req_full,
      .cmd_valid, .cmd_data, .cmd_pop
   );

   updrq_back #(
      .PORT_SLOTS(PORT_SLOTS), .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_back (
      .clock, .reset, .cmd_valid, .cmd_data, .cmd_pop,
      .rsp_empty, .rsp_data, .rsp_pop
   );
endmodule
`default_nettype wire

// ===== sim/udp_demux_checker.sv =====
`timescale 1ns / 1ps
module udp_demux_checker
   import updrq_pkg::*;
   (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  req_type     req_data,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  rsp_type     rsp_data,
   input  logic        cfg_we,
   input  logic        cfg_sel,
   input  logic [63:0] cfg_value,
   output int          errors,
   output int          pending
   );
   logic [31:0] own_ip;
   logic [47:0] own_mac;
   logic        used [16];
   logic [15:0] bound_port [16];
   logic [3:0]  head [16];
   logic [3:0]  tail [16];
   logic [4:0]  count [16];
   logic [73:0] ring [256];
   rsp_type     expected_rsps [$];

   function automatic int lookup_slot(input logic [15:0] p);
      for (int i = 0; i < 16; i++)
         if (used[i] && bound_port[i] == p) return i;
      return -1;
   endfunction

   task automatic predict_request(input req_type r);
      rsp_type o;
      int s;
      o = '0;
      if (r.opcode == OP_BIND) begin
         if (lookup_slot(r.port) >= 0) o.status = ST_BOUND;
         else begin
            o.status = ST_TABLE_FULL;
            for (int i = 0; i < 16; i++)
               if (!used[i]) begin
                  used[i] = 1; bound_port[i] = r.port;
                  head[i] = 0; tail[i] = 0; count[i] = 0;
                  o.status = ST_OK;
                  break;
               end
         end
      end else if (r.opcode == OP_DELIVER) begin
         o.out_handle = r.payload_handle;
         s = lookup_slot(r.port);
         if (r.dest_ip != own_ip || r.dest_mac != own_mac || r.protocol != UDP_PROTO)
            o.status = ST_MISMATCH;
         else if (r.udp_length < UDP_HDR) o.status = ST_BAD_LENGTH;
         else if (s < 0) o.status = ST_NOT_BOUND;
         else if (count[s] >= 16) o.status = ST_QUEUE_FULL;
         else begin
            ring[s*16 + tail[s]] = {r.source_ip, r.source_port, r.payload_handle,
                                    r.udp_length - UDP_HDR};
            tail[s]++; count[s]++;
            o.status = ST_OK;
         end
      end else if (r.opcode == OP_RECEIVE) begin
         s = lookup_slot(r.port);
         if (s < 0) o.status = ST_NOT_BOUND;
         else if (count[s] == 0) o.status = ST_EMPTY;
         else begin
            {o.out_source_ip, o.out_source_port, o.out_handle, o.out_length} =
               ring[s*16 + head[s]];
            if (o.out_length > r.max_len) o.out_length = r.max_len;
            head[s]++; count[s]--;
            o.status = ST_OK;
         end
      end else return;
      expected_rsps.push_back(o);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         own_ip <= LOCAL_IP_RESET;
         own_mac <= LOCAL_MAC_RESET;
         for (int i = 0; i < 16; i++) begin
            used[i] = 0; bound_port[i] = 0; head[i] = 0; tail[i] = 0; count[i] = 0;
         end
         expected_rsps.delete();
         errors <= 0;
      end else begin
         if (cfg_we) begin
            if (cfg_sel == REG_LOCAL_IP) own_ip <= cfg_value[31:0];
            else own_mac <= cfg_value[47:0];
         end
         if (rsp_pop && !rsp_empty) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %h",
                        $time, rsp_data);
               errors <= errors + 1;
            end else if (expected_rsps[0] !== rsp_data) begin
               $display("%0t: response mismatch, expected %h, actual %h",
                        $time, expected_rsps[0], rsp_data);
               errors <= errors + 1;
               void'(expected_rsps.pop_front());
            end else void'(expected_rsps.pop_front());
         end
         if (req_push && !req_full) predict_request(req_data);
      end
   end

   assign pending = expected_rsps.size();
endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;
   import updrq_pkg::*;
   localparam int REQ_BITS = $bits(req_type);
   logic        clock = 0;
   logic        reset = 1;
   logic        csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [3:0]  csr_paddr = 0;
   logic [63:0] csr_pwdata = 0;
   logic [63:0] csr_prdata;
   logic        csr_pready;
   logic        req_push = 0;
   req_type     req_data = '0;
   logic        req_full, rsp_empty, rsp_pop = 0;
   rsp_type     rsp_data;
   int          errors, pending;
   logic [31:0] cur_ip = LOCAL_IP_RESET;
   logic [47:0] cur_mac = LOCAL_MAC_RESET;
   logic [15:0] port_pool [8];

   udp_port_demux_receive_queues_top dut (.*);

   udp_demux_checker checker_i (
      .clock, .reset, .req_push, .req_full, .req_data, .rsp_empty, .rsp_pop, .rsp_data,
      .cfg_we(csr_psel && csr_penable && csr_pwrite && csr_pready),
      .cfg_sel(csr_paddr[3]), .cfg_value(csr_pwdata), .errors, .pending);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   initial begin
      #200_000_000;
      $display("tb failed");
      $finish;
   end

   task automatic write_csr(input logic [0:0] idx, input logic [63:0] v);
      @(posedge clock);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= {idx, 3'b000}; csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      if (idx == REG_LOCAL_IP) cur_ip = v[31:0];
      else cur_mac = v[47:0];
   endtask

   task automatic send_request(input req_type r);
      int w;
      w = $urandom_range(0, 8);
      if (w > 0) begin
         req_push <= 0;
         repeat (w) @(posedge clock);
      end
      req_push <= 1;
      req_data <= r;
      do @(posedge clock); while (req_full);
   endtask

   task automatic drain_responses;
      req_push <= 0;
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   function automatic req_type random_request(input bit noise);
      req_type r;
      r = REQ_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      r.port = ($urandom_range(0, 9) == 0) ? 16'($urandom) : port_pool[$urandom_range(0, 7)];
      if (!noise) begin
         r.opcode = ($urandom_range(0, 9) == 0) ? OP_BIND
                  : ($urandom_range(0, 1) ? OP_DELIVER : OP_RECEIVE);
         r.dest_ip = cur_ip;
         r.dest_mac = cur_mac;
         r.protocol = UDP_PROTO;
         if ($urandom_range(0, 3) != 0) r.udp_length = 16'($urandom_range(8, 300));
         if ($urandom_range(0, 1)) r.max_len = 16'($urandom_range(0, 300));
      end
      return r;
   endfunction

   initial begin
      req_type r;
      repeat (8) @(posedge clock);
      reset <= 0;
      foreach (port_pool[i]) port_pool[i] = 16'($urandom);
      port_pool[0] = 16'h0000; port_pool[1] = 16'hFFFF;

      r = '0; r.dest_ip = cur_ip; r.dest_mac = cur_mac; r.protocol = UDP_PROTO;
      r.opcode = OP_RECEIVE; r.port = 16'hFFFF; send_request(r);
      r.opcode = OP_BIND; send_request(r);
      send_request(r);
      r.opcode = OP_RECEIVE; send_request(r);
      r.opcode = OP_DELIVER; r.udp_length = 16'd7; send_request(r);
      r.udp_length = 16'd8; r.source_ip = '1; r.source_port = '1; r.payload_handle = '1;
      send_request(r);
      r.udp_length = 16'hFFFF; send_request(r);
      r.protocol = 8'd6; send_request(r);
      r.protocol = UDP_PROTO; r.dest_mac = ~cur_mac; send_request(r);
      r.dest_mac = cur_mac; r.dest_ip = ~cur_ip; send_request(r);
      r.dest_ip = cur_ip; r.port = 16'h0000; send_request(r);
      r.opcode = 2'd3; send_request(r);
      r.opcode = OP_RECEIVE; r.port = 16'hFFFF; r.max_len = 16'hFFFF; send_request(r);
      r.max_len = 16'd0; send_request(r);
      for (int i = 0; i < 17; i++) begin
         r.opcode = OP_DELIVER; r.port = 16'hFFFF; r.udp_length = 16'(8 + i);
         send_request(r);
      end
      for (int i = 0; i < 16; i++) begin
         r.opcode = OP_BIND; r.port = 16'(i + 1); send_request(r);
      end
      drain_responses();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin write_csr(REG_LOCAL_IP, '0); write_csr(REG_LOCAL_MAC, '0); end
            1: begin write_csr(REG_LOCAL_IP, '1); write_csr(REG_LOCAL_MAC, '1); end
            default: begin
               write_csr(REG_LOCAL_IP, {$urandom, $urandom});
               write_csr(REG_LOCAL_MAC, {$urandom, $urandom});
            end
         endcase
         for (int k = 0; k < 300; k++) send_request(random_request($urandom_range(0, 9) == 0));
         drain_responses();
      end
      drain_responses();
      $display("Covered binds up to a full table, filtered and queued deliveries,");
      $display("receives with clipping, and six address settings including extremes.");
      if (errors == 0) $display("tb passed");
      else $display("tb failed");
      $finish;
   end

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && !rsp_empty) begin
            repeat ($urandom_range(0, 8)) @(posedge clock);
            rsp_pop <= 1;
            do @(posedge clock); while (rsp_empty);
            rsp_pop <= 0;
         end
      end
   end
endmodule
